// File: sv/tksr_pkg.sv
// Shared types and codes for the two-key SOCD resolver.
// Holds configuration, result and queue entry types; no dependencies.
`default_nettype none

package tksr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;

    localparam logic [2:0] POLICY_LAST      = 3'd0;
    localparam logic [2:0] POLICY_PRIMARY   = 3'd1;
    localparam logic [2:0] POLICY_SECONDARY = 3'd2;
    localparam logic [2:0] POLICY_NEUTRAL   = 3'd3;
    localparam logic [2:0] POLICY_DISTANCE  = 3'd4;

    localparam logic [1:0] REG_PRIMARY_KEY = 2'd0;
    localparam logic [1:0] REG_SECOND_KEY  = 2'd1;
    localparam logic [1:0] REG_POLICY      = 2'd2;
    localparam logic [1:0] REG_BOTTOM_OUT  = 2'd3;

    localparam logic ACT_REGISTER   = 1'b0;
    localparam logic ACT_UNREGISTER = 1'b1;

    typedef struct packed {
        logic [7:0] primary_key;
        logic [7:0] second_key;
        logic [2:0] policy;
        logic [7:0] bottom_out;
    } cfg_t;

    typedef struct packed {
        logic       action;
        logic [7:0] key;
        logic [7:0] keycode;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res_a;
        result_t res_b;
    } job_t;

endpackage

`default_nettype wire

// File: sv/tksr_front.sv
// Front end: accepts key events, updates the per-side state and builds
// the zero, one or two results each event causes. Depends on tksr_pkg.
`default_nettype none

module tksr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tksr_pkg::cfg_t   cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       key_position,
    input  wire logic [1:0]       mode,
    input  wire logic [7:0]       keycode,
    input  wire logic [7:0]       distance_primary,
    input  wire logic [7:0]       distance_secondary,
    input  wire logic             queue_full,
    output logic                  push,
    output tksr_pkg::job_t        push_job
);
    import tksr_pkg::*;

    logic [1:0][7:0] active_reg;
    logic [1:0][7:0] active_next;
    logic [1:0]      registered_reg;
    logic [1:0]      registered_next;

    logic            side;
    logic [1:0][7:0] keys;
    logic [1:0]      reg_a;
    logic [1:0]      want;
    logic            rel_hit;
    logic            chg0;
    logic            chg1;
    logic [7:0]      dist_s;
    logic [7:0]      dist_o;
    logic            accept;
    result_t         r_rel;
    result_t         r0;
    result_t         r1;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        keys[0]     = cfg.primary_key;
        keys[1]     = cfg.second_key;
        side        = (key_position == cfg.primary_key) ? 1'b0 : 1'b1;
        dist_s      = side ? distance_secondary : distance_primary;
        dist_o      = side ? distance_primary : distance_secondary;
        active_next = active_reg;
        reg_a       = registered_reg;
        rel_hit     = 1'b0;
        if (mode == MODE_PRESS)
        begin
            active_next[side] = keycode;
        end
        else if (mode == MODE_RELEASE)
        begin
            rel_hit           = registered_reg[side];
            reg_a[side]       = 1'b0;
            active_next[side] = '0;
        end

        want[0] = active_next[0] != '0;
        want[1] = active_next[1] != '0;
        if (want[0] && want[1])
        begin
            if (cfg.bottom_out != '0 && distance_primary >= cfg.bottom_out
                && distance_secondary >= cfg.bottom_out)
            begin
                want = 2'b11;
            end
            else if (cfg.policy == POLICY_DISTANCE)
            begin
                want[side]  = dist_s >= dist_o;
                want[~side] = !(dist_s >= dist_o);
            end
            else if (mode == MODE_PRESS)
            begin
                want[side] = (cfg.policy != POLICY_NEUTRAL)
                    && ((cfg.policy == POLICY_LAST)
                        || (cfg.policy == POLICY_PRIMARY && !side)
                        || (cfg.policy == POLICY_SECONDARY && side));
                want[~side] = (cfg.policy != POLICY_NEUTRAL) && !want[side];
            end
            else
            begin
                want = reg_a;
            end
        end
        registered_next = want;
    end

    always_comb
    begin
        r_rel.action  = ACT_UNREGISTER;
        r_rel.key     = keys[side];
        r_rel.keycode = active_reg[side];
        r0.action     = want[0] ? ACT_REGISTER : ACT_UNREGISTER;
        r0.key        = keys[0];
        r0.keycode    = active_next[0];
        r1.action     = want[1] ? ACT_REGISTER : ACT_UNREGISTER;
        r1.key        = keys[1];
        r1.keycode    = active_next[1];
        chg0          = want[0] != reg_a[0];
        chg1          = want[1] != reg_a[1];

        // A release never changes its own side a second time, so at most
        // two of the three possible results are present.
        if (rel_hit)
        begin
            push_job.two   = chg0 || chg1;
            push_job.res_a = r_rel;
            push_job.res_b = chg0 ? r0 : r1;
        end
        else if (chg0)
        begin
            push_job.two   = chg1;
            push_job.res_a = r0;
            push_job.res_b = r1;
        end
        else
        begin
            push_job.two   = 1'b0;
            push_job.res_a = r1;
            push_job.res_b = r1;
        end
        push = accept && (rel_hit || chg0 || chg1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            registered_reg <= '0;
        end
        else if (accept)
        begin
            active_reg     <= active_next;
            registered_reg <= registered_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tksr_queue.sv
// Short queue of result jobs between the front end and the output stage.
// Depends on tksr_pkg for the job type.
`default_nettype none

module tksr_queue #(
    parameter int DEPTH = tksr_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tksr_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output tksr_pkg::job_t      pop_job,
    output logic                empty
);
    import tksr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: sv/tksr_back.sv
// Output stage: takes jobs from the queue and presents their results one
// item per cycle on the output channel while out_ready is high. Depends on tksr_pkg.
`default_nettype none

module tksr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    output logic                pop,
    input  wire tksr_pkg::job_t pop_job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                action,
    output logic [7:0]          out_key,
    output logic [7:0]          out_keycode,
    output logic                last
);
    import tksr_pkg::*;

    logic    busy_reg;
    logic    busy_next;
    logic    phase_reg;
    logic    phase_next;
    job_t    job_reg;
    job_t    job_next;
    logic    done;
    result_t cur;

    assign done = busy_reg && out_ready && (phase_reg || !job_reg.two);
    assign pop  = !empty && (!busy_reg || done);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        job_next   = job_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            job_next   = pop_job;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        cur         = phase_reg ? job_reg.res_b : job_reg.res_a;
        out_valid   = busy_reg;
        action      = cur.action;
        out_key     = cur.key;
        out_keycode = cur.keycode;
        last        = phase_reg || !job_reg.two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

// File: sv/two_key_socd_resolver.sv
// Two-key SOCD resolver: configuration, front end, job queue and output stage;
// depends on tksr_pkg, tksr_front, tksr_queue and tksr_back.
// An item's results pass through the queue and the output stage's job register.
// Throughput: one result item per cycle while out_ready is high; an item with no
// result never enters the queue. Reset: asynchronous; clears key state, queue
// and output; configuration returns to 0, 1, last-pressed policy, bottom-out off.
`default_nettype none

module two_key_socd_resolver #(
    parameter int QUEUE_DEPTH = tksr_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] key_position,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] keycode,
    input  wire logic [7:0] distance_primary,
    input  wire logic [7:0] distance_secondary,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            action,
    output logic [7:0]      out_key,
    output logic [7:0]      out_keycode,
    output logic            last
);
    import tksr_pkg::*;

    cfg_t cfg_reg;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primary_key <= 8'd0;
            cfg_reg.second_key  <= 8'd1;
            cfg_reg.policy      <= POLICY_LAST;
            cfg_reg.bottom_out  <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRIMARY_KEY: cfg_reg.primary_key <= cfg_data;
                REG_SECOND_KEY:  cfg_reg.second_key  <= cfg_data;
                REG_POLICY:      cfg_reg.policy      <= cfg_data[2:0];
                REG_BOTTOM_OUT:  cfg_reg.bottom_out  <= cfg_data;
                default:         cfg_reg.bottom_out  <= cfg_reg.bottom_out;
            endcase
        end
    end

    tksr_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .key_position       (key_position),
        .mode               (mode),
        .keycode            (keycode),
        .distance_primary   (distance_primary),
        .distance_secondary (distance_secondary),
        .queue_full         (queue_full),
        .push               (push),
        .push_job           (push_job)
    );

    tksr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    tksr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (queue_empty),
        .pop         (pop),
        .pop_job     (pop_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .out_key     (out_key),
        .out_keycode (out_keycode),
        .last        (last)
    );

endmodule

`default_nettype wire

// File: test/two_key_socd_resolver_test.sv
// Self-checking testbench for two_key_socd_resolver: a directed table, then random key events.
// Every result is checked against the directed table's expectations or an in-bench SOCD resolution predictor.
// Depends on tksr_pkg and the two_key_socd_resolver RTL.

module two_key_socd_resolver_test;

    import tksr_pkg::*;

    localparam logic [1:0] MODE_OTHER = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] POLICY_SPARE = 3'd7;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic       action;
        logic [7:0] key;
        logic [7:0] keycode;
        logic       last;
    } key_result_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_index;
        logic [7:0]  reg_value;
        logic [7:0]  pos;
        logic [1:0]  md;
        logic [7:0]  code;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic        typed;
        logic [1:0]  n_typed;
        key_result_t r0;
        key_result_t r1;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] key_position = '0;
    logic [1:0] mode = '0;
    logic [7:0] keycode = '0;
    logic [7:0] distance_primary = '0;
    logic [7:0] distance_secondary = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       action;
    logic [7:0] out_key;
    logic [7:0] out_keycode;
    logic       last;

    stim_row_t   current_row = '0;
    stim_row_t   directed_rows[$];
    key_result_t pending_results[$];
    key_result_t predicted_batch[$];

    logic [7:0] cur_primary = 8'd0;
    logic [7:0] cur_secondary = 8'd1;
    logic [2:0] cur_policy = POLICY_LAST;
    logic [7:0] cur_bottom = 8'd0;
    logic [7:0] side_code[2] = '{8'd0, 8'd0};
    logic       side_registered[2] = '{1'b0, 1'b0};

    logic sender_idle_on = 1'b1;
    logic sink_idle_on = 1'b1;
    int   error_count = 0;

    two_key_socd_resolver u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .key_position(key_position),
        .mode(mode),
        .keycode(keycode),
        .distance_primary(distance_primary),
        .distance_secondary(distance_secondary),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .action(action),
        .out_key(out_key),
        .out_keycode(out_keycode),
        .last(last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic key_result_t mk_res(input logic act, input logic [7:0] key,
                                           input logic [7:0] code, input logic fin);
        key_result_t r;
        r.action = act;
        r.key = key;
        r.keycode = code;
        r.last = fin;
        return r;
    endfunction

    function automatic void add_event(input logic [7:0] pos, input logic [1:0] md,
                                      input logic [7:0] code, input logic [7:0] d0,
                                      input logic [7:0] d1);
        stim_row_t r;
        r = '0;
        r.pos = pos;
        r.md = md;
        r.code = code;
        r.d0 = d0;
        r.d1 = d1;
        directed_rows.push_back(r);
    endfunction

    function automatic void expect_typed(input logic [1:0] n, input key_result_t r0,
                                         input key_result_t r1);
        directed_rows[directed_rows.size() - 1].typed = 1'b1;
        directed_rows[directed_rows.size() - 1].n_typed = n;
        directed_rows[directed_rows.size() - 1].r0 = r0;
        directed_rows[directed_rows.size() - 1].r1 = r1;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [7:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        directed_rows.push_back(r);
    endfunction

    // Applies one key event to the predicted state and leaves its results in predicted_batch.
    function automatic void resolve_event(input logic [7:0] pos, input logic [1:0] md,
                                          input logic [7:0] code, input logic [7:0] d0,
                                          input logic [7:0] d1);
        logic [7:0] travel[2];
        logic [7:0] keys[2];
        logic       want[2];
        logic       neutral;
        logic       win;
        int         s;
        int         o;
        predicted_batch.delete();
        travel[0] = d0;
        travel[1] = d1;
        keys[0] = cur_primary;
        keys[1] = cur_secondary;
        s = (pos == cur_primary) ? 0 : 1;
        o = 1 - s;
        if (md == MODE_PRESS)
        begin
            side_code[s] = code;
        end
        else if (md == MODE_RELEASE)
        begin
            if (side_registered[s])
            begin
                predicted_batch.push_back(mk_res(ACT_UNREGISTER, keys[s], side_code[s], 1'b0));
                side_registered[s] = 1'b0;
            end
            side_code[s] = 8'd0;
        end
        want[0] = side_code[0] != 8'd0;
        want[1] = side_code[1] != 8'd0;
        if (want[0] && want[1])
        begin
            if (cur_bottom != 8'd0 && travel[0] >= cur_bottom && travel[1] >= cur_bottom)
            begin
                want[0] = 1'b1;
                want[1] = 1'b1;
            end
            else if (cur_policy == POLICY_DISTANCE)
            begin
                want[s] = travel[s] >= travel[o];
                want[o] = !want[s];
            end
            else if (md == MODE_PRESS)
            begin
                neutral = cur_policy == POLICY_NEUTRAL;
                win = !neutral && (cur_policy == POLICY_LAST ||
                                   (cur_policy == POLICY_PRIMARY && s == 0) ||
                                   (cur_policy == POLICY_SECONDARY && s == 1));
                want[s] = win;
                want[o] = !neutral && !win;
            end
            else
            begin
                want[0] = side_registered[0];
                want[1] = side_registered[1];
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (want[i] != side_registered[i])
            begin
                predicted_batch.push_back(mk_res(want[i] ? ACT_REGISTER : ACT_UNREGISTER,
                                                 keys[i], side_code[i], 1'b0));
                side_registered[i] = want[i];
            end
        end
        if (predicted_batch.size() > 0)
        begin
            predicted_batch[predicted_batch.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin
        key_result_t exp_res;
        key_result_t got_res;
        if (rst_n && in_valid && in_ready)
        begin
            resolve_event(key_position, mode, keycode, distance_primary, distance_secondary);
            if (current_row.typed)
            begin
                predicted_batch.delete();
                if (current_row.n_typed >= 2'd1)
                begin
                    predicted_batch.push_back(current_row.r0);
                end
                if (current_row.n_typed >= 2'd2)
                begin
                    predicted_batch.push_back(current_row.r1);
                end
            end
            foreach (predicted_batch[i])
            begin
                pending_results.push_back(predicted_batch[i]);
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            got_res = mk_res(action, out_key, out_keycode, last);
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result act=%0d key=%0d code=%0d last=%0d",
                                          action, out_key, out_keycode, last));
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got_res.action !== exp_res.action || got_res.key !== exp_res.key ||
                    got_res.keycode !== exp_res.keycode || got_res.last !== exp_res.last)
                begin
                    report_mismatch($sformatf(
                        "got act=%0d key=%0d code=%0d last=%0d, wanted %0d %0d %0d %0d",
                        got_res.action, got_res.key, got_res.keycode, got_res.last,
                        exp_res.action, exp_res.key, exp_res.keycode, exp_res.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !(sink_idle_on && ($urandom_range(99) < 30));
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PRIMARY_KEY: cur_primary = val;
            REG_SECOND_KEY:  cur_secondary = val;
            REG_POLICY:      cur_policy = val[2:0];
            REG_BOTTOM_OUT:  cur_bottom = val;
            default:         ;
        endcase
    endtask

    task automatic send_event(input stim_row_t r);
        while (sender_idle_on && ($urandom_range(99) < 30))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_position <= r.pos;
        mode <= r.md;
        keycode <= r.code;
        distance_primary <= r.d0;
        distance_secondary <= r.d1;
        current_row <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] random_distance();
        int t;
        if (cur_bottom != 8'd0 && $urandom_range(1) == 1)
        begin
            t = int'(cur_bottom) + int'($urandom_range(2)) - 1;
            if (t > 255)
            begin
                t = 255;
            end
            return 8'(t);
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic stim_row_t random_event();
        stim_row_t r;
        int pick;
        r = '0;
        pick = $urandom_range(99);
        r.pos = (pick < 45) ? cur_primary : (pick < 90) ? cur_secondary : 8'($urandom_range(255));
        pick = $urandom_range(99);
        r.md = (pick < 40) ? MODE_PRESS : (pick < 75) ? MODE_RELEASE :
               (pick < 95) ? MODE_OTHER : MODE_SPARE;
        r.code = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        r.d0 = random_distance();
        r.d1 = ($urandom_range(9) == 0) ? r.d0 : random_distance();
        return r;
    endfunction

    initial
    begin
        int drain_wait;
        logic [7:0] prim;
        logic [7:0] sec;
        // Typed rows assume the reset configuration: primary at 0, secondary at 1, last wins.
        add_event(8'd0, MODE_PRESS, 8'h41, 8'd0, 8'd0);
        expect_typed(2'd1, mk_res(ACT_REGISTER, 8'd0, 8'h41, 1'b1), '0);
        add_event(8'd1, MODE_PRESS, 8'h44, 8'd255, 8'd255);
        expect_typed(2'd2, mk_res(ACT_UNREGISTER, 8'd0, 8'h41, 1'b0),
                     mk_res(ACT_REGISTER, 8'd1, 8'h44, 1'b1));
        add_event(8'd1, MODE_RELEASE, 8'h00, 8'd0, 8'd0);
        expect_typed(2'd2, mk_res(ACT_UNREGISTER, 8'd1, 8'h44, 1'b0),
                     mk_res(ACT_REGISTER, 8'd0, 8'h41, 1'b1));
        add_event(8'd0, MODE_RELEASE, 8'hff, 8'd255, 8'd0);
        expect_typed(2'd1, mk_res(ACT_UNREGISTER, 8'd0, 8'h41, 1'b1), '0);
        add_event(8'd0, MODE_OTHER, 8'hff, 8'd0, 8'd255);
        expect_typed(2'd0, '0, '0);
        add_event(8'd255, MODE_SPARE, 8'h80, 8'd128, 8'd127);
        expect_typed(2'd0, '0, '0);
        add_event(8'd255, MODE_PRESS, 8'hff, 8'd255, 8'd0);
        expect_typed(2'd1, mk_res(ACT_REGISTER, 8'd1, 8'hff, 1'b1), '0);
        add_event(8'd0, MODE_PRESS, 8'h00, 8'd0, 8'd0);
        expect_typed(2'd0, '0, '0);
        add_event(8'd0, MODE_PRESS, 8'h01, 8'd0, 8'd0);
        expect_typed(2'd2, mk_res(ACT_REGISTER, 8'd0, 8'h01, 1'b0),
                     mk_res(ACT_UNREGISTER, 8'd1, 8'hff, 1'b1));
        add_event(8'd0, MODE_PRESS, 8'h02, 8'd10, 8'd20);
        add_event(8'd1, MODE_OTHER, 8'h00, 8'd20, 8'd10);
        add_event(8'd0, MODE_RELEASE, 8'h00, 8'd0, 8'd0);
        add_cfg(REG_POLICY, {5'd0, POLICY_DISTANCE});
        add_event(8'd0, MODE_PRESS, 8'h10, 8'd100, 8'd100);
        add_event(8'd1, MODE_OTHER, 8'h00, 8'd50, 8'd200);
        add_event(8'd0, MODE_OTHER, 8'h00, 8'd0, 8'd255);
        add_cfg(REG_BOTTOM_OUT, 8'd255);
        add_event(8'd0, MODE_OTHER, 8'h00, 8'd255, 8'd255);
        add_event(8'd1, MODE_OTHER, 8'h00, 8'd254, 8'd255);
        add_cfg(REG_POLICY, {5'd0, POLICY_NEUTRAL});
        add_cfg(REG_BOTTOM_OUT, 8'd1);
        add_event(8'd1, MODE_PRESS, 8'h20, 8'd0, 8'd0);
        add_event(8'd1, MODE_OTHER, 8'h00, 8'd1, 8'd1);
        add_cfg(REG_POLICY, {5'b11111, POLICY_SPARE});
        add_cfg(REG_BOTTOM_OUT, 8'd0);
        add_event(8'd0, MODE_PRESS, 8'h30, 8'd5, 8'd5);
        add_cfg(REG_PRIMARY_KEY, 8'h5a);
        add_cfg(REG_SECOND_KEY, 8'h5a);
        add_event(8'h5a, MODE_PRESS, 8'h77, 8'd0, 8'd0);
        add_event(8'h5a, MODE_RELEASE, 8'h00, 8'd0, 8'd0);
        add_cfg(REG_SECOND_KEY, 8'ha5);
        add_cfg(REG_POLICY, {5'd0, POLICY_PRIMARY});
        add_event(8'h5a, MODE_PRESS, 8'h66, 8'd0, 8'd0);
        add_event(8'ha5, MODE_PRESS, 8'h55, 8'd0, 8'd0);
        add_cfg(REG_POLICY, {5'd0, POLICY_SECONDARY});
        add_event(8'h5a, MODE_PRESS, 8'h99, 8'd0, 8'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                send_event(directed_rows[i]);
            end
        end

        for (int phase = 0; phase < 12; phase++)
        begin
            prim = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255 : 8'($urandom_range(255));
            sec = (phase == 0) ? 8'd1 : (phase == 2) ? 8'd0 :
                  (phase == 5) ? prim : 8'($urandom_range(255));
            write_reg(REG_PRIMARY_KEY, prim);
            write_reg(REG_SECOND_KEY, sec);
            write_reg(REG_POLICY, (phase >= 8) ? {5'($urandom_range(31)), 3'(phase % 8)}
                                               : 8'(phase % 8));
            case ((phase == 0) ? 0 : $urandom_range(3))
                0:       write_reg(REG_BOTTOM_OUT, 8'd0);
                1:       write_reg(REG_BOTTOM_OUT, 8'd1);
                2:       write_reg(REG_BOTTOM_OUT, 8'd255);
                default: write_reg(REG_BOTTOM_OUT, 8'($urandom_range(254, 2)));
            endcase
            sender_idle_on = !(phase == 6 || phase == 7);
            sink_idle_on = !(phase == 6 || phase == 7);
            for (int n = 0; n < 170; n++)
            begin
                if ($urandom_range(199) == 0)
                begin
                    wait_drained();
                end
                send_event(random_event());
            end
        end

        in_valid <= 1'b0;
        drain_wait = 0;
        @(posedge clk);
        while (pending_results.size() != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
